/* sv/url_percent_decoder_top_assert.svh */
`ifndef URL_PERCENT_DECODER_TOP_ASSERT_SVH
`define URL_PERCENT_DECODER_TOP_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define UPD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that implies another in the same cycle.
`define UPD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* sv/upd_pkg.sv */
`timescale 1ns / 1ps

package upd_pkg;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;

  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_word_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            last;
  } grp_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) ||
           (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

/* sv/url_percent_decoder_top.sv */
// The first decoded byte of a word goes through the group queue, then the output register.
// One input word per cycle unless full; one decoded word per cycle while the receiver pops.
// A word that expands to two or three bytes leaves as that many output words, one per pop.
// A four-entry group queue between the decoder and the serializer absorbs such bursts.
// Reset is asynchronous and active low; it clears the escape state, the queue and the output valid flag.
`timescale 1ns / 1ps

module url_percent_decoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  upd_pkg::in_word_t  in_word_i,
  output logic               empty,
  input  logic               pop,
  output upd_pkg::out_word_t out_word_o
);
  import upd_pkg::*;

  `include "url_percent_decoder_top_assert.svh"

  logic accept;
  logic q_push, q_pop, q_full, q_empty;
  grp_t q_grp, q_head;

  assign full   = q_full;
  assign accept = push && !q_full;

  upd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_word_i (in_word_i),
    .q_push_o  (q_push),
    .q_grp_o   (q_grp)
  );

  upd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_grp),
    .pop_i   (q_pop),
    .rdata_o (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  upd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (q_head),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_word_o (out_word_o)
  );

  `UPD_ASSERT_ALWAYS(a_queue_sane, !(q_full && q_empty), "group queue both full and empty")
  `UPD_ASSERT_IMPLY(a_push_nonempty, q_push, q_grp.cnt != 2'd0, "empty group pushed")
  `UPD_ASSERT_IMPLY(a_head_nonempty, !q_empty, q_head.cnt != 2'd0, "empty group at queue head")
  `UPD_ASSERT_IMPLY(a_pop_guarded, q_pop, !q_empty, "group popped from empty queue")

endmodule

/* sv/upd_front.sv */
`timescale 1ns / 1ps

module upd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  upd_pkg::in_word_t in_word_i,
  output logic              q_push_o,
  output upd_pkg::grp_t     q_grp_o
);
  import upd_pkg::*;

  localparam logic [1:0] PhIdle  = 2'd0;
  localparam logic [1:0] PhPct   = 2'd1;
  localparam logic [1:0] PhDigit = 2'd2;

  logic [1:0]      phase_q, phase_d;
  logic [7:0]      held_q, held_d;
  logic [2:0][7:0] seq;
  logic [1:0]      n;
  logic            consumed;
  logic            hex;
  logic [7:0]      b;

  always_comb begin
    b        = in_word_i.in_byte;
    hex      = is_hex(b);
    held_d   = held_q;
    phase_d  = PhIdle;
    seq      = '0;
    n        = 2'd0;
    consumed = 1'b0;

    unique case (phase_q)
      PhPct: begin
        if (hex) begin
          held_d   = b;
          phase_d  = PhDigit;
          consumed = 1'b1;
        end else begin
          seq[n] = ChPercent;
          n      = n + 2'd1;
        end
      end
      PhDigit: begin
        if (hex) begin
          seq[n]   = {hex_value(held_q), hex_value(b)};
          n        = n + 2'd1;
          consumed = 1'b1;
        end else begin
          seq[n] = ChPercent;
          n      = n + 2'd1;
          seq[n] = held_q;
          n      = n + 2'd1;
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase

    if (!consumed) begin
      if (b == ChPercent) begin
        phase_d = PhPct;
      end else if (b == ChPlus) begin
        seq[n] = ChSpace;
        n      = n + 2'd1;
      end else begin
        seq[n] = b;
        n      = n + 2'd1;
      end
    end

    if (in_word_i.in_last) begin
      if (phase_d == PhPct) begin
        seq[n] = ChPercent;
        n      = n + 2'd1;
      end else if (phase_d == PhDigit) begin
        seq[n] = ChPercent;
        n      = n + 2'd1;
        seq[n] = held_d;
        n      = n + 2'd1;
      end
      phase_d = PhIdle;
    end
  end

  assign q_grp_o.bytes = seq;
  assign q_grp_o.cnt   = n;
  assign q_grp_o.last  = in_word_i.in_last;
  assign q_push_o      = accept_i && (n != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      held_q  <= 8'h00;
    end else if (accept_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

/* sv/upd_fifo.sv */
`timescale 1ns / 1ps

module upd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  upd_pkg::grp_t wdata_i,
  input  logic          pop_i,
  output upd_pkg::grp_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);
  import upd_pkg::*;

  grp_t              mem_q [FifoDepth];
  logic [FifoAw-1:0] wptr_q, rptr_q;
  logic [FifoAw:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (FifoAw + 1)'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == FifoAw'(FifoDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == FifoAw'(FifoDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* sv/upd_back.sv */
`timescale 1ns / 1ps

module upd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  upd_pkg::grp_t      head_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output upd_pkg::out_word_t out_word_o
);
  import upd_pkg::*;

  logic       valid_q, valid_d;
  logic [1:0] idx_q, idx_d;
  out_word_t  out_q, out_d;
  logic       load, is_end;

  assign is_end  = (idx_q == head_i.cnt - 2'd1);
  assign load    = !q_empty_i && (!valid_q || pop_i);
  assign q_pop_o = load && is_end;

  always_comb begin
    out_d.out_byte = head_i.bytes[idx_q];
    out_d.out_last = head_i.last && is_end;
    idx_d          = idx_q;
    valid_d        = valid_q;
    if (load) begin
      idx_d   = is_end ? 2'd0 : idx_q + 2'd1;
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  assign empty_o    = !valid_q;
  assign out_word_o = out_q;

endmodule

/* tb/sv/url_percent_decoder_checker.sv */
`timescale 1ns / 1ps

module url_percent_decoder_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_i,
  input  upd_pkg::in_word_t  in_word_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  upd_pkg::out_word_t out_word_i,
  output int                 errors_o,
  output int                 waiting_o,
  output int                 checked_o
);

  import upd_pkg::*;

  typedef enum logic [1:0] {
    EscIdle,
    EscPercent,
    EscDigit
  } esc_state_e;

  esc_state_e esc_state;
  logic [7:0] first_digit;
  out_word_t  decoded_words[$];

  initial begin
    errors_o  = 0;
    waiting_o = 0;
    checked_o = 0;
  end

  // Returns the digit value in the low four bits and a valid flag on top.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end
    if (c inside {[8'h41:8'h46]}) begin
      d = c - 8'h41 + 8'd10;
      return {1'b1, d[3:0]};
    end
    if (c inside {[8'h61:8'h66]}) begin
      d = c - 8'h61 + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'b0_0000;
  endfunction

  task automatic add_decoded(input logic [7:0] b);
    out_word_t w;
    w.out_byte = b;
    w.out_last = 1'b0;
    decoded_words.push_back(w);
  endtask

  task automatic decode_word(input in_word_t w);
    logic [4:0] cur;
    logic [4:0] held;
    logic       consumed;
    int         base_size;
    out_word_t  tail;
    cur       = hex_digit(w.in_byte);
    held      = hex_digit(first_digit);
    consumed  = 1'b0;
    base_size = decoded_words.size();
    case (esc_state)
      EscPercent: begin
        if (cur[4]) begin
          first_digit = w.in_byte;
          esc_state   = EscDigit;
          consumed    = 1'b1;
        end else begin
          add_decoded(ChPercent);
          esc_state = EscIdle;
        end
      end
      EscDigit: begin
        if (cur[4]) begin
          add_decoded({held[3:0], cur[3:0]});
          consumed = 1'b1;
        end else begin
          add_decoded(ChPercent);
          add_decoded(first_digit);
        end
        esc_state = EscIdle;
      end
      default: esc_state = EscIdle;
    endcase
    if (!consumed) begin
      if (w.in_byte == ChPercent) begin
        esc_state = EscPercent;
      end else if (w.in_byte == ChPlus) begin
        add_decoded(ChSpace);
      end else begin
        add_decoded(w.in_byte);
      end
    end
    if (w.in_last) begin
      if (esc_state == EscPercent) begin
        add_decoded(ChPercent);
      end else if (esc_state == EscDigit) begin
        add_decoded(ChPercent);
        add_decoded(first_digit);
      end
      esc_state = EscIdle;
      if (decoded_words.size() > base_size) begin
        tail = decoded_words.pop_back();
        tail.out_last = 1'b1;
        decoded_words.push_back(tail);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t ns: mismatch on %s, got %02h, expected %02h", $time, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      esc_state   = EscIdle;
      first_digit = 8'h00;
      decoded_words.delete();
    end else begin
      // The output side is checked first, since a word accepted at this edge
      // cannot already be on the result ports.
      if (pop_i && !empty_i) begin
        checked_o++;
        if (decoded_words.size() == 0) begin
          report_mismatch("unexpected result word", out_word_i.out_byte, 8'h00);
        end else begin
          want = decoded_words.pop_front();
          if (out_word_i.out_byte !== want.out_byte) begin
            report_mismatch("out_byte", out_word_i.out_byte, want.out_byte);
          end
          if (out_word_i.out_last !== want.out_last) begin
            report_mismatch("out_last", {7'd0, out_word_i.out_last}, {7'd0, want.out_last});
          end
        end
      end
      if (push_i && !full_i) begin
        decode_word(in_word_i);
      end
    end
    waiting_o = decoded_words.size();
  end

endmodule

/* tb/sv/tb_url_percent_decoder_top.sv */
`timescale 1ns / 1ps

module tb_url_percent_decoder_top;

  import upd_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_word_t  in_word;
  logic      empty;
  logic      pop;
  out_word_t out_word;

  int errors;
  int waiting;
  int checked;
  int sent;
  int send_idle;
  int recv_idle;
  int holds_done;
  bit hold_request;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  url_percent_decoder_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word)
  );

  url_percent_decoder_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_i     (full),
    .in_word_i  (in_word),
    .empty_i    (empty),
    .pop_i      (pop),
    .out_word_i (out_word),
    .errors_o   (errors),
    .waiting_o  (waiting),
    .checked_o  (checked)
  );

  initial begin
    #1_000_000;
    $display("url_percent_decoder_top test failed");
    $finish;
  end

  // The receiver honors a hold request by keeping pop low for a long stretch.
  initial begin
    pop = 1'b0;
    holds_done = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        pop <= 1'b0;
        repeat (60) @(posedge clk_i);
        hold_request = 1'b0;
        holds_done++;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic mark_last);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push            <= 1'b1;
    in_word.in_byte <= b;
    in_word.in_last <= mark_last;
    do @(posedge clk_i); while (full);
    sent++;
  endtask

  task automatic send_text(input string s, input logic mark_last);
    for (int i = 0; i < s.len(); i++) begin
      send_word(s[i], mark_last && (i == s.len() - 1));
    end
  endtask

  function automatic logic [7:0] random_hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) begin
      return 8'h30 + v[7:0];
    end
    return ($urandom_range(1) ? 8'h41 : 8'h61) + v[7:0] - 8'd10;
  endfunction

  // Mostly well-formed escapes, with plus signs, lone percent signs, stray digits and
  // arbitrary bytes mixed in.
  task automatic send_random_string();
    logic [7:0] text[$];
    int         len;
    int         pick;
    len = $urandom_range(8, 1);
    while (text.size() < len) begin
      pick = $urandom_range(9);
      if (pick < 4) begin
        text.push_back(ChPercent);
        text.push_back(random_hex_char());
        text.push_back(random_hex_char());
      end else if (pick == 4) begin
        text.push_back(ChPlus);
      end else if (pick == 5) begin
        text.push_back(ChPercent);
      end else if (pick == 6) begin
        text.push_back(random_hex_char());
      end else begin
        text.push_back(8'($urandom_range(255)));
      end
    end
    foreach (text[i]) begin
      send_word(text[i], i == text.size() - 1);
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    push         = 1'b0;
    in_word      = '0;
    sent         = 0;
    send_idle    = 12;
    recv_idle    = 67;
    hold_request = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_text("+%09%fF%G%4z%%41", 1'b0);
    send_text("%a%", 1'b1);
    send_text("x%", 1'b1);
    send_text("%A", 1'b1);

    for (int mix = 0; mix < 3; mix++) begin
      if (mix == 1) begin
        send_idle = 67;
        recv_idle = 12;
      end else if (mix == 2) begin
        send_idle    = 0;
        recv_idle    = 0;
        hold_request = 1'b1;
      end
      while (sent < 25 + (mix + 1) * 30) begin
        send_random_string();
      end
    end
    push <= 1'b0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d encoded words and checked %0d decoded words.", sent, checked);
    $display("Covered three stall mixes and %0d long output hold-off(s).", holds_done);
    if (errors == 0) begin
      $display("url_percent_decoder_top test passed");
    end else begin
      $display("url_percent_decoder_top test failed");
    end
    $finish;
  end

endmodule
